FILE: hw/rtl/thcs_pkg.sv
// ----------------------------------------------------------------------------
// thcs_pkg
// types and constants shared by the twelve-hour clock with save block
// ----------------------------------------------------------------------------
package thcs_pkg;

  localparam int unsigned HOUR_W   = 4;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CFG_W    = 16;

  localparam logic [CFG_W-1:0]    SAVE_INTERVAL_RST = 16'd45000;
  localparam logic [CFG_W-1:0]    SECOND_PERIOD_RST = 16'd1000;
  localparam logic [SECOND_W-1:0] SECOND_MAX        = 6'd59;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX        = 6'd59;
  localparam logic [HOUR_W-1:0]   HOUR_MAX          = 4'd12;
  localparam logic [HOUR_W-1:0]   HOUR_FIRST        = 4'd1;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_SAVE = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_SAVE_INTERVAL = 1'b0,
    CFG_SECOND_PERIOD = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } hms_t;

  typedef struct packed {
    mode_t           mode;
    logic [MS_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    hms_t hms;
    logic saved;
  } result_t;

endpackage

FILE: hw/rtl/thcs_engine.sv
// ----------------------------------------------------------------------------
// thcs_engine
// clock and save state, updated once per transaction in a single pass
// ----------------------------------------------------------------------------
module thcs_engine (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  thcs_pkg::item_t          item,
  input  logic [thcs_pkg::CFG_W-1:0] save_interval,
  input  logic [thcs_pkg::CFG_W-1:0] second_period,
  output thcs_pkg::result_t        result
);
  import thcs_pkg::*;

  hms_t            time_r,  time_nxt;
  hms_t            saved_r, saved_nxt;
  logic [MS_W-1:0] ref_r,   ref_nxt;
  logic [MS_W-1:0] last_r,  last_nxt;
  hms_t            rolled;
  logic [MS_W-1:0] elapsed;
  logic [MS_W-1:0] since_save;
  logic            did_save;

  always_comb begin
    rolled     = time_r;
    elapsed    = item.now_ms - ref_r;
    since_save = item.now_ms - last_r;
    time_nxt   = time_r;
    saved_nxt  = saved_r;
    ref_nxt    = ref_r;
    last_nxt   = last_r;
    did_save   = 1'b0;
    // rollovers first
    if (rolled.second > SECOND_MAX) begin
      rolled.second = '0;
      rolled.minute = rolled.minute + MINUTE_W'(1);
    end
    if (rolled.minute > MINUTE_MAX) begin
      rolled.minute = '0;
      rolled.hour   = rolled.hour + HOUR_W'(1);
    end
    if (rolled.hour > HOUR_MAX) begin
      rolled.hour = HOUR_FIRST;
    end
    if (item.mode == MODE_TICK) begin
      time_nxt = rolled;
      if (elapsed > MS_W'(second_period)) begin
        time_nxt.second = rolled.second + SECOND_W'(1);
        ref_nxt         = ref_r + MS_W'(second_period);
      end
    end else if (since_save >= MS_W'(save_interval)) begin
      last_nxt = item.now_ms;
      if (time_r != saved_r) begin
        saved_nxt = time_r;
        did_save  = 1'b1;
      end
    end
  end

  assign result.hms   = time_nxt;
  assign result.saved = did_save;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      saved_r <= '0;
      ref_r   <= '0;
      last_r  <= '0;
    end else if (go) begin
      time_r  <= time_nxt;
      saved_r <= saved_nxt;
      ref_r   <= ref_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

FILE: hw/rtl/twelve_hour_clock_with_save_top.sv
// ----------------------------------------------------------------------------
// twelve_hour_clock_with_save_top
// twelve-hour clock counter driven by ms timestamps, with periodic save check
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_mode, in_now_ms
// out      output     out_valid / out_ready  out_hour_out, out_minute_out,
//                                            out_second_out, out_saved
// cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
// one transaction per cycle while the result is not stalled; path is input register, then result register
// state update is one combinational pass in the engine between those registers
// reset is synchronous, active low; config resets to 45000 / 1000
// a stalled result holds the pipe; input is still taken while the input stage is free
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_save_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [thcs_pkg::MS_W-1:0]     in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [thcs_pkg::HOUR_W-1:0]   out_hour_out,
  output logic [thcs_pkg::MINUTE_W-1:0] out_minute_out,
  output logic [thcs_pkg::SECOND_W-1:0] out_second_out,
  output logic                          out_saved,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [thcs_pkg::CFG_W-1:0]    cfg_wdata
);
  import thcs_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic             out_valid_r;
  result_t          out_res_r;
  result_t          res;
  logic [CFG_W-1:0] save_interval_r;
  logic [CFG_W-1:0] second_period_r;
  logic             stall;
  logic             advance;
  logic             in_fire;

  assign stall        = out_valid_r && !out_ready;
  assign advance      = s1_valid_r && !stall;
  assign in_ready     = !s1_valid_r || !stall;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      save_interval_r <= SAVE_INTERVAL_RST;
      second_period_r <= SECOND_PERIOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAVE_INTERVAL: save_interval_r <= cfg_wdata;
        CFG_SECOND_PERIOD: second_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (!stall) begin
        out_valid_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode   <= mode_t'(in_mode);
      s1_item_r.now_ms <= in_now_ms;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  thcs_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (advance),
    .item          (s1_item_r),
    .save_interval (save_interval_r),
    .second_period (second_period_r),
    .result        (res)
  );

  assign out_valid      = out_valid_r;
  assign out_hour_out   = out_res_r.hms.hour;
  assign out_minute_out = out_res_r.hms.minute;
  assign out_second_out = out_res_r.hms.second;
  assign out_saved      = out_res_r.saved;

endmodule
